// ===== src/tts_pkg.sv =====
// Shared types and constants of the two-triangle source time function generator.
`default_nettype none
package tts_pkg;

  localparam int QW  = 32;  // quotient width of the shared divider
  localparam int DW  = 48;  // divisor and remainder width of the shared divider
  localparam int SHW = 17;  // shape sample width, Q1.16
  localparam int LW  = 7;   // run length width

  localparam logic [31:0] ONE_Q16      = 32'd65536;
  localparam logic [31:0] TWO_Q16      = 32'd131072;
  localparam logic [15:0] BETA_DEEP    = 16'd13107;
  localparam logic [15:0] BETA_SHALLOW = 16'd32768;
  localparam logic [14:0] BETA_RANGE   = 15'd19661;
  localparam logic [23:0] DEPTH_LOW    = 24'd262144;
  localparam logic [23:0] DEPTH_HIGH   = 24'd393216;

  typedef enum logic [1:0] {
    CFG_MIN_SLIP,
    CFG_RISE_TIME,
    CFG_SAMPLE_INTERVAL,
    CFG_SAMPLE_COUNT
  } cfg_idx_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== src/tts_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow flag.
`default_nettype none
module tts_div #(
  parameter int DW = 48
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [DW+tts_pkg::QW-1:0] num,
  input  wire logic [DW-1:0]             den,
  output logic [tts_pkg::QW-1:0]         quo,
  output logic [DW-1:0]                  rem,
  output tts_pkg::div_stat_t             stat
);

  localparam int QW = tts_pkg::QW;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [QW-1:0] low_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic          ovf_r;

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  assign trial   = {rem_r, low_r[QW-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num[DW+QW-1:QW];
        low_r  <= num[QW-1:0];
        den_r  <= den;
        ovf_r  <= num[DW+QW-1:QW] >= den;
        cnt_r  <= CW'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        low_r <= {low_r[QW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = low_r;
  assign rem       = rem_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule
`default_nettype wire

// ===== src/two_triangle_stf_generator.sv =====
// Top level of the two-triangle source time function generator.
// One source is taken when start is high and busy is low; busy then stays high
// until the last result of that source has been shown. A source with slip at or
// below min_slip, or a sample_count below two, gives one empty result (length 0,
// last set) through the S_EMPTY state, as does a shape with no nonzero sample.
// Otherwise the block runs its single shared 32-step divider four times for the
// shape timing (three times when the tail is empty), builds the shape at one
// sample per cycle over the buffer length, and then, for each emitted sample,
// reads the shape store, multiplies by the slip and divides.
// Results appear on out_* for exactly one cycle with out_valid high; there is
// no back pressure, so the receiver must take every result when it is shown.
// Configuration is to be written only while busy is low; the block does not enforce it.
`default_nettype none
module two_triangle_stf_generator #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_slip_amount,
  input  wire logic [23:0] in_source_depth,
  output logic             out_valid,
  output logic [31:0]      out_sample_value,
  output logic [5:0]       out_sample_index,
  output logic [6:0]       out_wave_length,
  output logic             out_last_sample
);

  localparam int QW  = tts_pkg::QW;
  localparam int DW  = tts_pkg::DW;
  localparam int NW  = DW + QW;
  localparam int SHW = tts_pkg::SHW;
  localparam int LW  = tts_pkg::LW;
  localparam int AW  = $clog2(MAX_SAMPLES);

  typedef enum logic [3:0] {
    S_IDLE, S_BETA, S_DIV_IT0, S_DIV_IT1, S_IT2, S_DIV_STEP, S_DIV_TAIL,
    S_FILL, S_DEN, S_RD, S_MUL, S_DIV_OUT, S_EMPTY
  } state_t;

  // Configuration registers
  logic [31:0] min_slip_r;
  logic [23:0] rise_time_r;
  logic [23:0] sample_interval_r;
  logic [6:0]  sample_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_slip_r        <= 32'd0;
      rise_time_r       <= 24'd65536;
      sample_interval_r <= 24'd6554;
      sample_count_r    <= 7'd64;
    end else if (cfg_we) begin
      case (tts_pkg::cfg_idx_t'(cfg_index))
        tts_pkg::CFG_MIN_SLIP:        min_slip_r        <= cfg_data;
        tts_pkg::CFG_RISE_TIME:       rise_time_r       <= cfg_data[23:0];
        tts_pkg::CFG_SAMPLE_INTERVAL: sample_interval_r <= cfg_data[23:0];
        tts_pkg::CFG_SAMPLE_COUNT:    sample_count_r    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  state_t        state_r;
  logic          div_wait_r;
  logic [31:0]   slip_r;
  logic [23:0]   depth_r;
  logic [15:0]   beta_r;
  logic [31:0]   it0_r, it1_r, it2_r, span_r;
  logic [31:0]   q1_step_r, r1_step_r, q2_step_r, r2_step_r;
  logic [31:0]   q1_r, r1_r, q2_r, r2_r;
  logic [LW-1:0] k_r, nt_r, last_nz_r, len_r;
  logic [23:0]   sum_r;
  logic [DW-1:0] den_r;
  logic [48:0]   prod_r;
  logic [SHW-1:0] mem_q_r;

  logic          out_valid_r;
  logic [31:0]   out_value_r;
  logic [5:0]    out_index_r;
  logic [LW-1:0] out_len_r;
  logic          out_last_r;

  // Sample interval of zero counts as one step
  logic [23:0] dt;
  assign dt = (sample_interval_r == 24'd0) ? 24'd1 : sample_interval_r;

  // Buffer length, clipped to the store depth
  logic [LW-1:0] nt_c;
  assign nt_c = (32'(sample_count_r) > MAX_SAMPLES) ? LW'(MAX_SAMPLES) : sample_count_r;

  // Tail height from depth: clamped linear ramp between 4 and 6 km
  logic [16:0] depth_off;
  logic [31:0] ramp_prod;
  logic [15:0] beta_c;
  assign depth_off = 17'(tts_pkg::DEPTH_HIGH - depth_r);
  assign ramp_prod = 32'(depth_off) * 32'(tts_pkg::BETA_RANGE);
  always_comb begin
    if (depth_r >= tts_pkg::DEPTH_HIGH) begin
      beta_c = tts_pkg::BETA_DEEP;
    end else if (depth_r > tts_pkg::DEPTH_LOW) begin
      beta_c = tts_pkg::BETA_DEEP + 16'(ramp_prod >> 17);
    end else begin
      beta_c = tts_pkg::BETA_SHALLOW;
    end
  end

  // End of the first triangle: (2 - beta) * it0
  logic [49:0] it2_prod;
  assign it2_prod = 50'(18'(tts_pkg::TWO_Q16) - 18'(beta_r)) * 50'(it0_r);

  // Shared divider operands
  logic               div_start;
  logic [NW-1:0]      div_num;
  logic [DW-1:0]      div_den;
  logic [QW-1:0]      div_quo;
  logic [DW-1:0]      div_rem;
  tts_pkg::div_stat_t div_stat;
  logic               in_div;

  assign in_div = (state_r == S_DIV_IT0) || (state_r == S_DIV_IT1) ||
                  (state_r == S_DIV_STEP) || (state_r == S_DIV_TAIL) ||
                  (state_r == S_DIV_OUT);
  assign div_start = in_div && !div_wait_r;

  always_comb begin
    case (state_r)
      S_DIV_IT0: begin
        div_num = NW'({3'b0, rise_time_r}) + NW'({3'b0, dt} << 2) + NW'(dt);
        div_den = DW'({4'b0, dt} << 3) + DW'({4'b0, dt} << 1);
      end
      S_DIV_IT1: begin
        div_num = NW'({2'b0, rise_time_r} << 1) + NW'(dt);
        div_den = DW'({1'b0, dt} << 1);
      end
      S_DIV_STEP: begin
        div_num = NW'(tts_pkg::ONE_Q16);
        div_den = DW'(it0_r);
      end
      S_DIV_TAIL: begin
        div_num = NW'(beta_r);
        div_den = DW'(span_r);
      end
      S_DIV_OUT: begin
        div_num = NW'({prod_r, 16'b0});
        div_den = den_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  tts_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .rem   (div_rem),
    .stat  (div_stat)
  );

  // Shape sample at k: rising edge, falling edge, then the tail ramp.
  // The two quotient/remainder accumulators track k*1/it0 and (k-it2)*beta/span.
  logic [31:0]    kx;
  logic [SHW-1:0] shape_v;
  logic [32:0]    r1_sum, r2_sum;
  logic           r1_wrap, r2_wrap;
  assign kx = 32'(k_r);
  always_comb begin
    if (kx < it0_r) begin
      shape_v = SHW'(q1_r);
    end else if (kx < it2_r) begin
      shape_v = SHW'(tts_pkg::TWO_Q16 - q1_r - 32'(r1_r != 32'd0));
    end else if (kx < it1_r) begin
      shape_v = SHW'(32'(beta_r) - q2_r);
    end else begin
      shape_v = '0;
    end
  end
  assign r1_sum  = {1'b0, r1_r} + {1'b0, r1_step_r};
  assign r1_wrap = r1_sum >= {1'b0, it0_r};
  assign r2_sum  = {1'b0, r2_r} + {1'b0, r2_step_r};
  assign r2_wrap = r2_sum >= {1'b0, span_r};

  // Shape store
  logic [SHW-1:0] shape_mem [MAX_SAMPLES];
  logic [AW-1:0]  mem_addr;
  assign mem_addr = AW'(k_r);

  always_ff @(posedge clk) begin
    if (state_r == S_FILL) begin
      shape_mem[mem_addr] <= shape_v;
    end
    mem_q_r <= shape_mem[mem_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_wait_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (in_div && !div_wait_r) begin
        div_wait_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            slip_r    <= in_slip_amount;
            depth_r   <= in_source_depth;
            nt_r      <= nt_c;
            k_r       <= '0;
            last_nz_r <= '0;
            sum_r     <= '0;
            q1_r      <= '0;
            r1_r      <= '0;
            q2_r      <= '0;
            r2_r      <= '0;
            if (in_slip_amount <= min_slip_r || nt_c < LW'(2)) begin
              state_r <= S_EMPTY;
            end else begin
              state_r <= S_BETA;
            end
          end
        end
        S_BETA: begin
          beta_r  <= beta_c;
          state_r <= S_DIV_IT0;
        end
        S_DIV_IT0: begin
          if (div_wait_r && div_stat.done) begin
            div_wait_r <= 1'b0;
            it0_r      <= (div_quo < 32'd2) ? 32'd2 : div_quo;
            state_r    <= S_DIV_IT1;
          end
        end
        S_DIV_IT1: begin
          if (div_wait_r && div_stat.done) begin
            div_wait_r <= 1'b0;
            it1_r      <= (div_quo < 32'd4) ? 32'd4 : div_quo;
            state_r    <= S_IT2;
          end
        end
        S_IT2: begin
          it2_r   <= 32'(it2_prod >> 16);
          state_r <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (div_wait_r && div_stat.done) begin
            div_wait_r <= 1'b0;
            q1_step_r  <= div_quo;
            r1_step_r  <= 32'(div_rem);
            span_r     <= it1_r - it2_r;
            q2_step_r  <= '0;
            r2_step_r  <= '0;
            // Skip the tail division when the tail is empty
            state_r    <= (it2_r < it1_r) ? S_DIV_TAIL : S_FILL;
          end
        end
        S_DIV_TAIL: begin
          if (div_wait_r && div_stat.done) begin
            div_wait_r <= 1'b0;
            q2_step_r  <= div_quo;
            r2_step_r  <= 32'(div_rem);
            state_r    <= S_FILL;
          end
        end
        S_FILL: begin
          sum_r <= sum_r + 24'(shape_v);
          if (shape_v != '0) begin
            last_nz_r <= k_r;
          end
          q1_r <= q1_r + q1_step_r + 32'(r1_wrap);
          r1_r <= r1_wrap ? 32'(r1_sum - {1'b0, it0_r}) : r1_sum[31:0];
          if (kx >= it2_r) begin
            q2_r <= q2_r + q2_step_r + 32'(r2_wrap);
            r2_r <= r2_wrap ? 32'(r2_sum - {1'b0, span_r}) : r2_sum[31:0];
          end
          if (k_r == nt_r - 1'b1) begin
            state_r <= S_DEN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DEN: begin
          k_r   <= '0;
          den_r <= DW'(48'(dt) * 48'(sum_r));
          // Trim trailing zeros, keep one sample past the last nonzero one
          len_r <= (last_nz_r < nt_r - 1'b1) ? last_nz_r + LW'(2) : nt_r;
          state_r <= (last_nz_r == '0) ? S_EMPTY : S_RD;
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= 49'(mem_q_r) * 49'(slip_r);
          state_r <= S_DIV_OUT;
        end
        S_DIV_OUT: begin
          if (div_wait_r && div_stat.done) begin
            div_wait_r  <= 1'b0;
            out_valid_r <= 1'b1;
            out_value_r <= div_stat.ovf ? '1 : div_quo;
            out_index_r <= 6'(k_r);
            out_len_r   <= len_r;
            out_last_r  <= (k_r == len_r - 1'b1);
            if (k_r == len_r - 1'b1) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_EMPTY: begin
          out_valid_r <= 1'b1;
          out_value_r <= '0;
          out_index_r <= '0;
          out_len_r   <= '0;
          out_last_r  <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_sample_index = out_index_r;
  assign out_wave_length  = out_len_r;
  assign out_last_sample  = out_last_r;

endmodule
`default_nettype wire

// ===== src/tts_chk.sv =====
// Port-level checker for the two-triangle generator, bound to the top level.
`default_nettype none
module tts_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_sample_value,
  input wire logic [5:0]  out_sample_index,
  input wire logic [6:0]  out_wave_length,
  input wire logic        out_last_sample
);

  // A taken transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  // The final result of a run frees the block in the same cycle
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_sample |-> !busy) else $error("busy after last result");

  // Empty run is a single zero result
  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wave_length == 7'd0 |->
      out_last_sample && out_sample_value == 32'd0 && out_sample_index == 6'd0)
    else $error("malformed empty result");

  // Last flag marks exactly the final index of a nonempty run
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wave_length != 7'd0 |->
      (out_last_sample == ({1'b0, out_sample_index} == out_wave_length - 7'd1)))
    else $error("last flag does not match index");

endmodule

bind two_triangle_stf_generator tts_chk u_tts_chk (.*);
`default_nettype wire
